// ===== hdl/varc_pkg.sv =====
// Shared types and constants of the video aspect ratio calculator.
package varc_pkg;

  // Default frame dimension width.
  localparam int unsigned DIM_BITS_DEF = 12;

  // Aspect format codes carried on the input.
  typedef enum logic [1:0] {
    FMT_SQUARE  = 2'd0,
    FMT_4_3     = 2'd1,
    FMT_16_9    = 2'd2,
    FMT_221_100 = 2'd3
  } aspect_fmt_e;

  // Fixed display aspect terms, indexed by format code (square reads as 1:1).
  localparam logic [7:0] FIXED_NUM [4] = '{8'd1, 8'd4, 8'd16, 8'd221};
  localparam logic [6:0] FIXED_DEN [4] = '{7'd1, 7'd3, 7'd9, 7'd100};

  // Divider status handed back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hdl/video_aspect_ratio_calculator_unit.sv =====
// Top level of the video aspect ratio calculator: sequencer around a shared divider.
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+------------------------------------------
//  in      | input     | in_valid_i/in_ready_o  | frame_width, frame_height, aspect_format
//  out     | output    | out_valid_o/out_ready_i| display_num/den, pixel_num/den
//
//  Every remainder of the Euclid loop and both reducing divisions go through the one
//  shift-subtract divider, W = DIM_BITS + 8 bits wide, at a bit per cycle.
//  The input takes no new word until the current one has been written to the output
//  register. Reset clears the sequencer, the divider control and the output valid.
//  A stalled output holds the finished word; the sequencer waits in its last state.
module video_aspect_ratio_calculator_unit #(
  parameter int unsigned DIM_BITS = varc_pkg::DIM_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [DIM_BITS-1:0] frame_width_i,
  input  logic [DIM_BITS-1:0] frame_height_i,
  input  logic [1:0]          aspect_format_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DIM_BITS-1:0] display_num_o,
  output logic [DIM_BITS-1:0] display_den_o,
  output logic [DIM_BITS+7:0] pixel_num_o,
  output logic [DIM_BITS+6:0] pixel_den_o
);
  import varc_pkg::*;

  // Working width: wide enough for the pixel aspect products.
  localparam int unsigned W = DIM_BITS + 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_EUC,
    ST_EUC_W,
    ST_RED_N,
    ST_RED_D,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [DIM_BITS-1:0] w_q, h_q;
  logic                square_q;
  logic [DIM_BITS-1:0] disp_num_q, disp_den_q;
  logic [W-1:0]        n_q, d_q;     // pair being reduced
  logic [W-1:0]        a_q, b_q;     // Euclid operands
  logic [W-1:0]        g_q;          // greatest common divisor
  logic                out_valid_q;
  logic [DIM_BITS-1:0] out_dnum_q, out_dden_q;
  logic [W-1:0]        out_pnum_q;
  logic [W-2:0]        out_pden_q;

  logic [2*DIM_BITS-1:0] prod_n, prod_d;
  logic [W-1:0]          n_init, d_init;

  logic       div_start;
  logic [W-1:0] div_dividend, div_divisor;
  div_stat_t  div_stat;
  logic [W-1:0] div_quo, div_rem;

  // Pixel aspect terms: display terms crossed with the frame size.
  assign prod_n = disp_num_q * h_q;
  assign prod_d = disp_den_q * w_q;
  assign n_init = square_q ? W'(w_q) : prod_n[W-1:0];
  assign d_init = square_q ? W'(h_q) : prod_d[W-1:0];

  // Divider launch and operand selection.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = a_q;
    div_divisor  = b_q;
    unique case (state_q)
      ST_EUC: begin
        if (b_q != '0) begin
          // Next Euclid remainder.
          div_start = 1'b1;
        end else if (a_q != '0) begin
          // Euclid done, a is the divisor: reduce the numerator.
          div_start    = 1'b1;
          div_dividend = n_q;
          div_divisor  = a_q;
        end
      end
      ST_RED_N: begin
        div_start    = div_stat.done;
        div_dividend = d_q;
        div_divisor  = g_q;
      end
      default: begin
      end
    endcase
  end

  varc_divider #(
    .WIDTH(W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // Raise the output word from the final state, drop it once it is taken.
      if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_EUC;
        end
        ST_EUC: begin
          if (b_q != '0) begin
            state_q <= ST_EUC_W;
          end else if (a_q == '0) begin
            // Both terms zero: leave the pair unreduced.
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_RED_N;
          end
        end
        ST_EUC_W: begin
          if (div_stat.done) begin
            state_q <= ST_EUC;
          end
        end
        ST_RED_N: begin
          if (div_stat.done) begin
            state_q <= ST_RED_D;
          end
        end
        ST_RED_D: begin
          if (div_stat.done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          w_q        <= frame_width_i;
          h_q        <= frame_height_i;
          square_q   <= (aspect_format_i == FMT_SQUARE);
          disp_num_q <= DIM_BITS'(FIXED_NUM[aspect_format_i]);
          disp_den_q <= DIM_BITS'(FIXED_DEN[aspect_format_i]);
        end
      end
      ST_MUL: begin
        n_q <= n_init;
        d_q <= d_init;
        a_q <= n_init;
        b_q <= d_init;
      end
      ST_EUC: begin
        if (b_q == '0) begin
          g_q <= a_q;
        end
      end
      ST_EUC_W: begin
        if (div_stat.done) begin
          a_q <= b_q;
          b_q <= div_rem;
        end
      end
      ST_RED_N: begin
        if (div_stat.done) begin
          n_q <= div_quo;
        end
      end
      ST_RED_D: begin
        if (div_stat.done) begin
          d_q <= div_quo;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          if (square_q) begin
            out_dnum_q <= n_q[DIM_BITS-1:0];
            out_dden_q <= d_q[DIM_BITS-1:0];
            out_pnum_q <= W'(1);
            out_pden_q <= (W-1)'(1);
          end else begin
            out_dnum_q <= disp_num_q;
            out_dden_q <= disp_den_q;
            out_pnum_q <= n_q;
            out_pden_q <= d_q[W-2:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign display_num_o = out_dnum_q;
  assign display_den_o = out_dden_q;
  assign pixel_num_o   = out_pnum_q;
  assign pixel_den_o   = out_pden_q;

  // An accepted word closes the input until its result is written.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input still open after accept");

  // Never launch the divider while it is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider launched while busy");

  // Never divide by zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> div_divisor != '0)
    else $error("divider launched with zero divisor");

  // A new output word only comes from the final state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_DONE)
    else $error("output word raised outside final state");

endmodule

// ===== hdl/varc_divider.sv =====
// Restoring shift-subtract divider, one quotient bit per cycle.
module varc_divider #(
  parameter int unsigned WIDTH = varc_pkg::DIM_BITS_DEF + 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [WIDTH-1:0]    dividend_i,
  input  logic [WIDTH-1:0]    divisor_i,
  output varc_pkg::div_stat_t stat_o,
  output logic [WIDTH-1:0]    quotient_o,
  output logic [WIDTH-1:0]    remainder_o
);
  import varc_pkg::*;

  localparam int unsigned CntBits = $clog2(WIDTH + 1);

  logic               active_q;
  logic               done_q;
  logic [CntBits-1:0] cnt_q;
  logic [WIDTH-1:0]   rem_q;
  logic [WIDTH-1:0]   quo_q;
  logic [WIDTH-1:0]   den_q;
  logic [WIDTH:0]     shifted;
  logic [WIDTH:0]     trial;

  // Bring down the next dividend bit and try a subtract.
  assign shifted = {rem_q, quo_q[WIDTH-1]};
  assign trial   = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !active_q) begin
        active_q <= 1'b1;
        cnt_q    <= CntBits'(WIDTH);
      end else if (active_q) begin
        cnt_q <= cnt_q - CntBits'(1);
        if (cnt_q == CntBits'(1)) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !active_q) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (active_q) begin
      if (!trial[WIDTH]) begin
        rem_q <= trial[WIDTH-1:0];
        quo_q <= {quo_q[WIDTH-2:0], 1'b1};
      end else begin
        rem_q <= shifted[WIDTH-1:0];
        quo_q <= {quo_q[WIDTH-2:0], 1'b0};
      end
    end
  end

  assign stat_o.busy  = active_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = quo_q;
  assign remainder_o  = rem_q;

endmodule
